// ===== sv/bn254_base_field_montgomery_multiply_defines.svh =====
// assertion macros for the bn254 field multiplier checker
// needs clk and arst_n in the scope where a macro is used
`ifndef BN254_BASE_FIELD_MONTGOMERY_MULTIPLY_DEFINES_SVH
`define BN254_BASE_FIELD_MONTGOMERY_MULTIPLY_DEFINES_SVH

// same-cycle implication
`define BFMM_AST_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BFMM_AST_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/bfmm_pkg.sv =====
// shared constants for the bn254 base-field montgomery multiplier
// no dependencies
package bfmm_pkg;

	localparam int LIMB_W   = 64;
	localparam int HALF_W   = 32;
	localparam int OPER_W   = 256;
	localparam int WIDE_W   = 512;
	localparam int ROW_W    = OPER_W + HALF_W;
	localparam int PAIR_W   = OPER_W + LIMB_W;
	localparam int HALVES   = OPER_W / HALF_W;
	localparam int PROD_STG = 4;
	localparam int RED_STG  = 5;

	localparam logic [OPER_W-1:0] MOD_Q =
		256'h30644e72e131a029_b85045b68181585d_97816a916871ca8d_3c208c16d87cfd47;
	localparam logic [LIMB_W-1:0] QINV = 64'h87d20782e4866389;

endpackage

// ===== sv/bfmm_prod.sv =====
// schoolbook 256x256 product, four pipeline stages
// uses bfmm_pkg; 32x32 partial products merged by offset adds
module bfmm_prod (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [bfmm_pkg::OPER_W-1:0] a,
	input  logic [bfmm_pkg::OPER_W-1:0] b,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [bfmm_pkg::WIDE_W-1:0] t
);

	logic [bfmm_pkg::PROD_STG-1:0] vld_q;
	logic [bfmm_pkg::PROD_STG-1:0] adv;

	logic [2*bfmm_pkg::HALF_W-1:0] p_s1 [bfmm_pkg::HALVES][bfmm_pkg::HALVES];
	logic [bfmm_pkg::OPER_W-1:0]   e_row [bfmm_pkg::HALVES];
	logic [bfmm_pkg::OPER_W-1:0]   o_row [bfmm_pkg::HALVES];
	logic [bfmm_pkg::ROW_W-1:0]    row_s2 [bfmm_pkg::HALVES];
	logic [bfmm_pkg::PAIR_W-1:0]   pair_s3 [bfmm_pkg::HALVES/2];
	logic [bfmm_pkg::WIDE_W-1:0]   t_s4;

	always_comb begin
		adv[bfmm_pkg::PROD_STG-1] = !vld_q[bfmm_pkg::PROD_STG-1] | out_ready;
		for (int k = bfmm_pkg::PROD_STG-2; k >= 0; k--) begin
			adv[k] = !vld_q[k] | adv[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < bfmm_pkg::PROD_STG; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// even and odd partial products of each row sit side by side without overlap
	always_comb begin
		for (int y = 0; y < bfmm_pkg::HALVES; y++) begin
			for (int k = 0; k < bfmm_pkg::HALVES/2; k++) begin
				e_row[y][k*bfmm_pkg::LIMB_W +: bfmm_pkg::LIMB_W] = p_s1[y][2*k];
				o_row[y][k*bfmm_pkg::LIMB_W +: bfmm_pkg::LIMB_W] = p_s1[y][2*k+1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			for (int y = 0; y < bfmm_pkg::HALVES; y++) begin
				for (int x = 0; x < bfmm_pkg::HALVES; x++) begin
					p_s1[y][x] <= a[x*bfmm_pkg::HALF_W +: bfmm_pkg::HALF_W]
						* b[y*bfmm_pkg::HALF_W +: bfmm_pkg::HALF_W];
				end
			end
		end
		if (adv[1]) begin
			for (int y = 0; y < bfmm_pkg::HALVES; y++) begin
				row_s2[y] <= {32'b0, e_row[y]} + {o_row[y], 32'b0};
			end
		end
		if (adv[2]) begin
			for (int k = 0; k < bfmm_pkg::HALVES/2; k++) begin
				pair_s3[k] <= {32'b0, row_s2[2*k]} + {row_s2[2*k+1], 32'b0};
			end
		end
		if (adv[3]) begin
			t_s4 <= bfmm_pkg::WIDE_W'(pair_s3[0])
				+ (bfmm_pkg::WIDE_W'(pair_s3[1]) << 64)
				+ (bfmm_pkg::WIDE_W'(pair_s3[2]) << 128)
				+ (bfmm_pkg::WIDE_W'(pair_s3[3]) << 192);
		end
	end

	assign in_ready  = adv[0];
	assign out_valid = vld_q[bfmm_pkg::PROD_STG-1];
	assign t         = t_s4;

endmodule

// ===== sv/bfmm_round.sv =====
// one word-wise montgomery reduction round, five pipeline stages
// uses bfmm_pkg; limb index comes in on rnd
module bfmm_round (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [1:0]                  rnd,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [bfmm_pkg::WIDE_W-1:0] t_in,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [bfmm_pkg::WIDE_W-1:0] t_out
);

	logic [bfmm_pkg::RED_STG-1:0] vld_q;
	logic [bfmm_pkg::RED_STG-1:0] adv;

	logic [bfmm_pkg::LIMB_W-1:0] limb;
	logic [bfmm_pkg::LIMB_W-1:0] ll_s1;
	logic [bfmm_pkg::HALF_W-1:0] lh_s1;
	logic [bfmm_pkg::HALF_W-1:0] hl_s1;
	logic [bfmm_pkg::LIMB_W-1:0] m_s2;
	logic [bfmm_pkg::LIMB_W-1:0] pq_s3 [2][bfmm_pkg::HALVES];
	logic [bfmm_pkg::OPER_W-1:0] e_mq [2];
	logic [bfmm_pkg::OPER_W-1:0] o_mq [2];
	logic [bfmm_pkg::PAIR_W-1:0] mq_s4;
	logic [bfmm_pkg::WIDE_W-1:0] t_s1, t_s2, t_s3, t_s4, t_s5;

	always_comb begin
		adv[bfmm_pkg::RED_STG-1] = !vld_q[bfmm_pkg::RED_STG-1] | out_ready;
		for (int k = bfmm_pkg::RED_STG-2; k >= 0; k--) begin
			adv[k] = !vld_q[k] | adv[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < bfmm_pkg::RED_STG; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign limb = t_in[{rnd, 6'b0} +: bfmm_pkg::LIMB_W];

	always_comb begin
		for (int h = 0; h < 2; h++) begin
			for (int k = 0; k < bfmm_pkg::HALVES/2; k++) begin
				e_mq[h][k*bfmm_pkg::LIMB_W +: bfmm_pkg::LIMB_W] = pq_s3[h][2*k];
				o_mq[h][k*bfmm_pkg::LIMB_W +: bfmm_pkg::LIMB_W] = pq_s3[h][2*k+1];
			end
		end
	end

	always_ff @(posedge clk) begin
		// m = limb * qinv mod 2^64 from three half products
		if (adv[0]) begin
			ll_s1 <= limb[31:0] * bfmm_pkg::QINV[31:0];
			lh_s1 <= bfmm_pkg::HALF_W'(limb[31:0] * bfmm_pkg::QINV[63:32]);
			hl_s1 <= bfmm_pkg::HALF_W'(limb[63:32] * bfmm_pkg::QINV[31:0]);
			t_s1  <= t_in;
		end
		if (adv[1]) begin
			m_s2 <= ll_s1 + {lh_s1 + hl_s1, 32'b0};
			t_s2 <= t_s1;
		end
		if (adv[2]) begin
			for (int h = 0; h < 2; h++) begin
				for (int k = 0; k < bfmm_pkg::HALVES; k++) begin
					pq_s3[h][k] <= m_s2[h*bfmm_pkg::HALF_W +: bfmm_pkg::HALF_W]
						* bfmm_pkg::MOD_Q[k*bfmm_pkg::HALF_W +: bfmm_pkg::HALF_W];
				end
			end
			t_s3 <= t_s2;
		end
		if (adv[3]) begin
			mq_s4 <= {64'b0, e_mq[0]} + {32'b0, o_mq[0], 32'b0}
				+ {32'b0, e_mq[1], 32'b0} + {o_mq[1], 64'b0};
			t_s4 <= t_s3;
		end
		// carry out of the top limb falls off here
		if (adv[4]) begin
			t_s5 <= t_s4 + (bfmm_pkg::WIDE_W'(mq_s4) << {rnd, 6'b0});
		end
	end

	assign in_ready  = adv[0];
	assign out_valid = vld_q[bfmm_pkg::RED_STG-1];
	assign t_out     = t_s5;

endmodule

// ===== sv/bfmm_final.sv =====
// final conditional subtraction of the modulus and output register
// uses bfmm_pkg
module bfmm_final (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [bfmm_pkg::WIDE_W-1:0] t_in,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [bfmm_pkg::OPER_W-1:0] r
);

	logic                        vld_q;
	logic                        adv;
	logic [bfmm_pkg::OPER_W-1:0] hi;
	logic [bfmm_pkg::OPER_W:0]   diff;
	logic [bfmm_pkg::OPER_W-1:0] r_q;

	assign adv  = !vld_q | out_ready;
	assign hi   = t_in[bfmm_pkg::WIDE_W-1 -: bfmm_pkg::OPER_W];
	assign diff = {1'b0, hi} - {1'b0, bfmm_pkg::MOD_Q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= in_valid;
		end
	end

	// no borrow means hi >= q
	always_ff @(posedge clk) begin
		if (adv) begin
			r_q <= diff[bfmm_pkg::OPER_W] ? hi : diff[bfmm_pkg::OPER_W-1:0];
		end
	end

	assign in_ready  = adv;
	assign out_valid = vld_q;
	assign r         = r_q;

endmodule

// ===== sv/bn254_base_field_montgomery_multiply.sv =====
// top level of the bn254 base-field montgomery multiplier
// uses bfmm_pkg, bfmm_prod, bfmm_round, bfmm_final
//
//   channel  dir  data                         width
//   s_*      in   a_word0..3, b_word0..3       512
//   m_*      out  prod_word0..3                256
//
// one operand pair per cycle while m_tready does not stall the output; a pair passes
// through 4 product stages, 4 rounds of 5 stages and 1 correction stage
// the 64x64 products run as 32x32 partial products, one register level each
// arst_n clears only the stage valid bits
// a stall holds every full stage; empty stages ahead of it still fill
module bn254_base_field_montgomery_multiply (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [511:0] s_tdata,  // a_word0, a_word1, a_word2, a_word3, b_word0..b_word3
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [255:0] m_tdata   // prod_word0, prod_word1, prod_word2, prod_word3
);

	logic                        vld [5];
	logic                        rdy [5];
	logic [bfmm_pkg::WIDE_W-1:0] tv  [5];

	bfmm_prod u_prod (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.a         (s_tdata[255:0]),
		.b         (s_tdata[511:256]),
		.out_valid (vld[0]),
		.out_ready (rdy[0]),
		.t         (tv[0])
	);

	for (genvar i = 0; i < 4; i++) begin : g_round
		bfmm_round u_round (
			.clk       (clk),
			.arst_n    (arst_n),
			.rnd       (2'(i)),
			.in_valid  (vld[i]),
			.in_ready  (rdy[i]),
			.t_in      (tv[i]),
			.out_valid (vld[i+1]),
			.out_ready (rdy[i+1]),
			.t_out     (tv[i+1])
		);
	end

	bfmm_final u_final (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld[4]),
		.in_ready  (rdy[4]),
		.t_in      (tv[4]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.r         (m_tdata)
	);

endmodule

// ===== sv/bfmm_checker.sv =====
// port-level checks for the bn254 montgomery multiplier
// uses bn254_base_field_montgomery_multiply_defines.svh; bound to the top level
`include "bn254_base_field_montgomery_multiply_defines.svh"

module bfmm_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [255:0] m_tdata
);

	`BFMM_AST_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
	`BFMM_AST_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "stalled result changed")
	`BFMM_AST_NOW(a_empty_ready, !m_tvalid, s_tready, "input blocked with empty output")
	`BFMM_AST_NOW(a_drain_ready, m_tready, s_tready, "input blocked while output drains")

endmodule

bind bn254_base_field_montgomery_multiply bfmm_checker u_bfmm_checker (.*);
